>>> rtl/wasc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wasc_pkg: shared types and constants for the window average block
// Sample type, reset values and the sequencer state encoding.
// ----------------------------------------------------------------------------
package wasc_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int WINDOW_DEF = 8;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Limit register after reset
    localparam sample_t MAX_DEV_RST = sample_t'(16);
    // Neutral elements that enter the head of the partial chain
    localparam sample_t MIN_IDENT   = '1;
    localparam sample_t MAX_IDENT   = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

>>> rtl/wasc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wasc_cell: one window cell
// Holds one sample of the window (shifted on transfer) and folds it into the
// running sum/min/max that ripples from its left neighbor.
// ----------------------------------------------------------------------------
module wasc_cell
    import wasc_pkg::*;
#(
    parameter int SUM_W = SAMPLE_W + 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  sample_t          sample_in,
    output sample_t          sample_out,
    input  logic [SUM_W-1:0] sum_in,
    input  sample_t          min_in,
    input  sample_t          max_in,
    output logic [SUM_W-1:0] sum_out,
    output sample_t          min_out,
    output sample_t          max_out
);

    sample_t          sample_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    sample_t          min_reg;
    sample_t          min_next;
    sample_t          max_reg;
    sample_t          max_next;

    // Ring entry; reset value counts in the window like any sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (shift_en)
        begin
            sample_reg <= sample_in;
        end
    end

    always_comb
    begin
        sum_next = sum_in + SUM_W'(sample_reg);
        min_next = (sample_reg < min_in) ? sample_reg : min_in;
        max_next = (sample_reg > max_in) ? sample_reg : max_in;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign sample_out = sample_reg;
    assign sum_out    = sum_reg;
    assign min_out    = min_reg;
    assign max_out    = max_reg;

endmodule

>>> rtl/wasc_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wasc_mean: mean and spread stage
// Divides the window sum by WINDOW through a reciprocal multiply (exact for
// the full sum range) and compares the spread against the limit.
// ----------------------------------------------------------------------------
module wasc_mean
    import wasc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                                clk,
    input  logic                                load,
    input  logic [SAMPLE_W+$clog2(WINDOW)-1:0]  sum,
    input  sample_t                             win_min,
    input  sample_t                             win_max,
    input  sample_t                             max_dev,
    output logic                                stable,
    output sample_t                             average
);

    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_W + LOG_W;
    localparam int SH     = SUM_W + LOG_W;
    localparam int MULT   = ((2 ** SH) + WINDOW - 1) / WINDOW;
    localparam int MULT_W = SH + 1;
    localparam int PROD_W = SUM_W + MULT_W;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              calm_reg;
    logic              calm_next;
    sample_t           spread;

    always_comb
    begin
        spread    = win_max - win_min;
        calm_next = (spread < max_dev);
        prod_next = PROD_W'(sum) * PROD_W'(MULT_W'(MULT));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            calm_reg <= calm_next;
        end
    end

    assign stable  = calm_reg;
    assign average = calm_reg ? prod_reg[SH +: SAMPLE_W] : '0;

endmodule

>>> rtl/window_average_with_stability_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_average_with_stability_check_core: moving average with range check
// Keeps the last WINDOW samples in a chain of cells and reports, for every
// sample, the truncated mean when the window spread is below the limit.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+---------------------------
//  in      | in_valid / in_stall       | sample[7:0]
//  out     | out_valid / out_stall     | stable, average[7:0]
//  cfg     | cfg_we (no wait)          | cfg_wdata[7:0] -> max_deviation
//
//  Each item passes the transfer, the ripple of the sum/min/max partials
//  through the cell chain (SCAN), the reciprocal multiply (DIV) and the
//  load of the output register (FIN), in that order.
//  in_stall is high while an item is in flight; the result waits in the
//  output register, so the next sample can be taken before it is drained.
//  A stalled output holds the finished stage, which then holds the input.
//  Reset zeroes all ring cells directly; no clearing pass is needed.
// ----------------------------------------------------------------------------
module window_average_with_stability_check_core
    import wasc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    // input samples
    input  logic    in_valid,
    output logic    in_stall,
    input  sample_t sample,
    // results
    output logic    out_valid,
    input  logic    out_stall,
    output logic    stable,
    output sample_t average,
    // limit register
    input  logic    cfg_we,
    input  sample_t cfg_wdata
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [CNT_W-1:0] scan_cnt_next;
    sample_t          max_dev_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_stable_reg;
    sample_t          out_average_reg;

    logic             in_xfer;
    logic             load_prod;
    logic             load_out;
    logic             mean_stable;
    sample_t          mean_average;

    // Chain links: index k feeds cell k, index WINDOW is the chain tail
    sample_t          samp_w [0:WINDOW-1];
    logic [SUM_W-1:0] sum_w  [0:WINDOW];
    sample_t          min_w  [0:WINDOW];
    sample_t          max_w  [0:WINDOW];

    assign in_xfer = in_valid && !in_stall;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dev_reg <= MAX_DEV_RST;
        end
        else if (cfg_we)
        begin
            max_dev_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------ cell chain
    // New sample enters cell 0, the oldest falls off the last cell.
    assign samp_w[0] = sample;
    assign sum_w[0]  = '0;
    assign min_w[0]  = MIN_IDENT;
    assign max_w[0]  = MAX_IDENT;

    for (genvar k = 0; k < WINDOW; k++)
    begin : g_cell
        if (k < WINDOW - 1)
        begin : g_mid
            wasc_cell #(
                .SUM_W (SUM_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (in_xfer),
                .sample_in  (samp_w[k]),
                .sample_out (samp_w[k+1]),
                .sum_in     (sum_w[k]),
                .min_in     (min_w[k]),
                .max_in     (max_w[k]),
                .sum_out    (sum_w[k+1]),
                .min_out    (min_w[k+1]),
                .max_out    (max_w[k+1])
            );
        end
        else
        begin : g_tail
            wasc_cell #(
                .SUM_W (SUM_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (in_xfer),
                .sample_in  (samp_w[k]),
                .sample_out (),
                .sum_in     (sum_w[k]),
                .min_in     (min_w[k]),
                .max_in     (max_w[k]),
                .sum_out    (sum_w[k+1]),
                .min_out    (min_w[k+1]),
                .max_out    (max_w[k+1])
            );
        end
    end

    // ------------------------------------------------------- mean and spread
    wasc_mean #(
        .WINDOW (WINDOW)
    ) u_mean (
        .clk     (clk),
        .load    (load_prod),
        .sum     (sum_w[WINDOW]),
        .win_min (min_w[WINDOW]),
        .win_max (max_w[WINDOW]),
        .max_dev (max_dev_reg),
        .stable  (mean_stable),
        .average (mean_average)
    );

    // ------------------------------------------------------------- sequencer
    // SCAN waits until the tail partials cover the new window.
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == CNT_W'(WINDOW - 1))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        load_prod = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_stall  = 1'b0;
            ST_SCAN: in_stall  = 1'b1;
            ST_DIV:  load_prod = 1'b1;
            ST_FIN:  load_out  = !out_valid_reg || !out_stall;
            default: in_stall  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    // --------------------------------------------------------- output stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_stable_reg  <= mean_stable;
            out_average_reg <= mean_average;
        end
    end

    assign out_valid = out_valid_reg;
    assign stable    = out_stable_reg;
    assign average   = out_average_reg;

    // ------------------------------------------------------------ assertions
    a_xfer_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_SCAN) && (scan_cnt_reg == '0))
        else $error("transfer did not start a scan");

    a_tail_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (min_w[WINDOW] <= max_w[WINDOW]))
        else $error("chain tail not settled when mean is loaded");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && out_valid_reg && out_stall) |=>
            (state_reg == ST_FIN))
        else $error("pending result overwritten");

    a_unstable_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stable_reg) |-> (out_average_reg == '0))
        else $error("unstable result with nonzero average");

endmodule
